@@ rtl/hrbp_pkg.sv @@
package hrbp_pkg;

  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2,
    ST_BIG  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_LINE = 3'd1,
    EV_HDR  = 3'd2,
    EV_END  = 3'd3,
    EV_BODY = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    HR_OK   = 2'd0,
    HR_FAIL = 2'd1,
    HR_BIG  = 2'd2
  } hres_e;

  // Commands from the controller to the datapath, valid for one accepted beat.
  typedef struct packed {
    logic restart;
    logic push;
    logic rl_end;
    logic hdr_end;
    logic body_push;
    logic body_clr;
  } cmd_t;

  // Status from the datapath, already seen through a pending restart.
  typedef struct packed {
    logic  is_cr;
    logic  is_lf;
    logic  line_empty;
    logic  line_full;
    logic  rl_ok;
    hres_e hdr_res;
    logic  body_full;
    logic  body_last;
    logic  body_go;
    logic [3:0] slot;
  } st_t;

  typedef struct packed {
    logic [2:0]  method;
    logic [10:0] content_length;
    logic [10:0] body_count;
  } res_t;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam int METHODS = 7;
  localparam int CL_NAME_LEN = 14;
  localparam int VER_PREFIX_LEN = 5;

  function automatic logic [3:0] method_len(input logic [2:0] k);
    logic [3:0] n;
    unique case (k)
      3'd0: n = 4'd3;
      3'd1: n = 4'd4;
      3'd2: n = 4'd3;
      3'd3: n = 4'd6;
      3'd4: n = 4'd4;
      3'd5: n = 4'd7;
      3'd6: n = 4'd5;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] method_char(input logic [2:0] k, input logic [3:0] p);
    logic [55:0] s;
    logic [3:0]  n;
    int          idx;
    unique case (k)
      3'd0: s = 56'("GET");
      3'd1: s = 56'("POST");
      3'd2: s = 56'("PUT");
      3'd3: s = 56'("DELETE");
      3'd4: s = 56'("HEAD");
      3'd5: s = 56'("OPTIONS");
      3'd6: s = 56'("PATCH");
      default: s = '0;
    endcase
    n = method_len(k);
    if (p >= n) return 8'h00;
    idx = int'(n) - 1 - int'(p);
    return s[8*idx +: 8];
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] p);
    logic [39:0] s;
    s = "HTTP/";
    if (p > 3'd4) return 8'h00;
    return s[8*(4 - int'(p)) +: 8];
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] p);
    logic [111:0] s;
    s = "content-length";
    if (p > 4'd13) return 8'h00;
    return s[8*(13 - int'(p)) +: 8];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

endpackage

@@ rtl/hrbp_datapath.sv @@
module hrbp_datapath #(
  parameter int LINE_MAX           = 128,
  parameter int BODY_MAX           = 1024,
  parameter int HEADER_STORE_BYTES = 512,
  parameter int HEADER_SLOTS       = 16,
  parameter int NAME_MAX           = 32,
  parameter int QUERY_MAX          = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        byte_i,
  input  hrbp_pkg::cmd_t    cmd_i,
  output hrbp_pkg::st_t     st_o,
  output hrbp_pkg::res_t    res_o
);
  import hrbp_pkg::*;

  localparam int LW   = $clog2(LINE_MAX + 1);
  localparam int BW   = $clog2(BODY_MAX + 1);
  localparam int UW   = $clog2(HEADER_STORE_BYTES + 1);
  localparam int SW   = $clog2(HEADER_SLOTS + 1);
  localparam int SUMW = $clog2(HEADER_STORE_BYTES + 2 * LINE_MAX + 4);
  localparam int AW   = $clog2(BODY_MAX + 2) + 4;

  // Per-line trackers; an all-zero value is the start of a line.
  typedef struct packed {
    logic [LW-1:0]      fill;
    logic [1:0]         tok;
    logic               in_tok;
    logic [LW-1:0]      tok_n;
    logic [METHODS-1:0] mmatch;
    logic [3:0]         mlen;
    logic               slash_ok;
    logic               q_seen;
    logic [LW-1:0]      q_len;
    logic               ver_ok;
    logic [3:0]         ver_n;
    logic               colon;
    logic [LW-1:0]      cpos;
    logic               skip;
    logic [LW-1:0]      vlen;
    logic               digits;
    logic               cl_ok;
    logic [AW-1:0]      acc;
  } trk_t;

  trk_t          trk_q, trk_d, e_trk;
  logic [UW-1:0] used_q, used_d, e_used;
  logic [SW-1:0] nst_q, nst_d, e_nst;
  logic [BW-1:0] bf_q, bf_d, e_bf;
  logic [BW-1:0] decl_q, decl_d, e_decl;
  logic          seen_q, seen_d, e_seen;
  logic [2:0]    meth_q, meth_d, e_meth;

  logic            blank, cut, three, ver_pass, is_cl, hfail;
  logic [LW-1:0]   pos, width;
  logic [AW-1:0]   acc_base, acc_new;
  logic [SUMW-1:0] name_end, val_end;
  logic [2:0]      mcode;
  logic [BW:0]     bf_inc;
  hres_e           hres;

  always_comb begin
    if (cmd_i.restart) begin
      e_trk  = '0;
      e_used = '0;
      e_nst  = '0;
      e_bf   = '0;
      e_decl = '0;
      e_seen = 1'b0;
      e_meth = '0;
    end else begin
      e_trk  = trk_q;
      e_used = used_q;
      e_nst  = nst_q;
      e_bf   = bf_q;
      e_decl = decl_q;
      e_seen = seen_q;
      e_meth = meth_q;
    end
  end

  // Line evaluation at LF, from the trackers and the header store counters.
  always_comb begin
    three    = (e_trk.tok == 2'd3) || (e_trk.tok == 2'd2 && e_trk.in_tok);
    ver_pass = three && e_trk.ver_ok && (e_trk.ver_n >= 4'(VER_PREFIX_LEN));
    mcode    = '0;
    for (int k = 0; k < METHODS; k++) begin
      if (e_trk.mmatch[k] && e_trk.mlen == method_len(3'(k))) mcode = 3'(k + 1);
    end
    name_end = SUMW'(e_used) + SUMW'(e_trk.cpos) + SUMW'(1);
    val_end  = name_end + SUMW'(e_trk.vlen) + SUMW'(1);
    hfail    = (e_nst >= SW'(HEADER_SLOTS)) || !e_trk.colon || (e_trk.cpos == '0) ||
               (32'(e_trk.cpos) > NAME_MAX) ||
               (name_end > SUMW'(HEADER_STORE_BYTES)) ||
               (val_end > SUMW'(HEADER_STORE_BYTES));
    is_cl    = e_trk.cl_ok && (e_trk.cpos == LW'(CL_NAME_LEN));
    if (hfail) hres = HR_FAIL;
    else if (is_cl && (e_trk.vlen == '0 || !e_trk.digits)) hres = HR_FAIL;
    else if (is_cl && e_trk.acc > AW'(BODY_MAX)) hres = HR_BIG;
    else hres = HR_OK;
    bf_inc = {1'b0, e_bf} + {{BW{1'b0}}, 1'b1};
  end

  // Byte intake: tokenizer of the request line and header field scan side by side.
  always_comb begin
    trk_d    = e_trk;
    blank    = (byte_i == CH_SP) || (byte_i == CH_TAB) ||
               (byte_i == CH_VT) || (byte_i == CH_FF);
    cut      = 1'b0;
    pos      = '0;
    acc_base = '0;
    acc_new  = '0;
    unique case (e_trk.tok)
      2'd0:    width = LW'(11);
      2'd1:    width = LW'(LINE_MAX);
      default: width = LW'(15);
    endcase
    if (cmd_i.push) begin
      if (e_trk.tok != 2'd3) begin
        if (blank) begin
          if (e_trk.in_tok) begin
            trk_d.tok    = e_trk.tok + 2'd1;
            trk_d.in_tok = 1'b0;
          end
        end else begin
          cut = e_trk.in_tok && (e_trk.tok_n == width);
          if (cut) trk_d.tok = e_trk.tok + 2'd1;
          pos = (!e_trk.in_tok || cut) ? '0 : e_trk.tok_n;
          if (trk_d.tok == 2'd3) begin
            trk_d.in_tok = 1'b0;
          end else begin
            trk_d.in_tok = 1'b1;
            trk_d.tok_n  = pos + LW'(1);
            unique case (trk_d.tok)
              2'd0: begin
                for (int k = 0; k < METHODS; k++) begin
                  trk_d.mmatch[k] = (pos == '0 || e_trk.mmatch[k]) &&
                                    (pos < LW'(method_len(3'(k)))) &&
                                    (byte_i == method_char(3'(k), pos[3:0]));
                end
                trk_d.mlen = pos[3:0] + 4'd1;
              end
              2'd1: begin
                if (pos == '0) trk_d.slash_ok = (byte_i == CH_SLASH);
                if (e_trk.q_seen) trk_d.q_len = e_trk.q_len + LW'(1);
                else if (byte_i == CH_QMARK) trk_d.q_seen = 1'b1;
              end
              default: begin
                trk_d.ver_n = pos[3:0] + 4'd1;
                if (pos < LW'(VER_PREFIX_LEN)) begin
                  trk_d.ver_ok = (pos == '0 || e_trk.ver_ok) &&
                                 (byte_i == ver_char(pos[2:0]));
                end
              end
            endcase
          end
        end
      end
      if (!e_trk.colon) begin
        if (byte_i == CH_COLON) begin
          trk_d.colon = 1'b1;
          trk_d.cpos  = e_trk.fill;
          trk_d.skip  = 1'b1;
        end else begin
          trk_d.cl_ok = (e_trk.fill == '0 || e_trk.cl_ok) &&
                        (e_trk.fill < LW'(CL_NAME_LEN)) &&
                        (to_lower(byte_i) == cl_char(e_trk.fill[3:0]));
        end
      end else if (!(e_trk.skip && (byte_i == CH_SP || byte_i == CH_TAB))) begin
        trk_d.skip   = 1'b0;
        trk_d.digits = (e_trk.vlen == '0 || e_trk.digits) &&
                       (byte_i >= 8'h30) && (byte_i <= 8'h39);
        acc_base     = (e_trk.vlen == '0) ? '0 : e_trk.acc;
        acc_new      = acc_base * AW'(10) + AW'(byte_i[3:0]);
        trk_d.acc    = (acc_new > AW'(BODY_MAX)) ? AW'(BODY_MAX + 1) : acc_new;
        trk_d.vlen   = e_trk.vlen + LW'(1);
      end
      trk_d.fill = e_trk.fill + LW'(1);
    end
    if (cmd_i.rl_end || cmd_i.hdr_end) trk_d = '0;
  end

  always_comb begin
    used_d = e_used;
    nst_d  = e_nst;
    bf_d   = e_bf;
    decl_d = e_decl;
    seen_d = e_seen;
    meth_d = e_meth;
    if (cmd_i.rl_end && ver_pass) meth_d = mcode;
    if (cmd_i.hdr_end && hres == HR_OK) begin
      nst_d  = e_nst + SW'(1);
      used_d = UW'(val_end);
      if (is_cl) begin
        seen_d = 1'b1;
        decl_d = BW'(e_trk.acc);
      end
    end
    if (cmd_i.body_push) bf_d = BW'(bf_inc);
    if (cmd_i.body_clr) bf_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q  <= '0;
      used_q <= '0;
      nst_q  <= '0;
      bf_q   <= '0;
      decl_q <= '0;
      seen_q <= 1'b0;
      meth_q <= '0;
    end else begin
      trk_q  <= trk_d;
      used_q <= used_d;
      nst_q  <= nst_d;
      bf_q   <= bf_d;
      decl_q <= decl_d;
      seen_q <= seen_d;
      meth_q <= meth_d;
    end
  end

  always_comb begin
    st_o.is_cr      = (byte_i == CH_CR);
    st_o.is_lf      = (byte_i == CH_LF);
    st_o.line_empty = (e_trk.fill == '0);
    st_o.line_full  = (32'(e_trk.fill) >= LINE_MAX);
    st_o.rl_ok      = ver_pass && e_trk.slash_ok &&
                      !(e_trk.q_seen && 32'(e_trk.q_len) > QUERY_MAX);
    st_o.hdr_res    = hres;
    st_o.body_full  = (32'(e_bf) >= BODY_MAX);
    st_o.body_last  = (bf_inc == {1'b0, e_decl});
    st_o.body_go    = e_seen && (e_decl != '0);
    st_o.slot       = 4'(e_nst);
    res_o.method         = meth_d;
    res_o.content_length = 11'(decl_d);
    res_o.body_count     = 11'(bf_d);
  end

endmodule

@@ rtl/hrbp_ctrl.sv @@
module hrbp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_start_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hrbp_pkg::cmd_t  cmd_o,
  input  hrbp_pkg::st_t   st_i,
  input  hrbp_pkg::res_t  res_i,
  output logic [1:0]      status_o,
  output logic [2:0]      event_o,
  output logic [3:0]      slot_o,
  output hrbp_pkg::res_t  res_o
);
  import hrbp_pkg::*;

  typedef enum logic [2:0] {
    PH_LINE, PH_HEAD, PH_BODY, PH_DONE, PH_ERR
  } phase_e;

  phase_e     ph_q, ph_d, e_ph;
  logic       accept;
  logic       ov_q;
  status_e    stat_d;
  event_e     ev_d;
  logic [3:0] slot_d;
  logic [1:0] status_q;
  logic [2:0] event_q;
  logic [3:0] slot_q;
  res_t       res_q;

  assign in_ready_o  = !ov_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign status_o    = status_q;
  assign event_o     = event_q;
  assign slot_o      = slot_q;
  assign res_o       = res_q;

  always_comb begin
    cmd_o  = '0;
    ph_d   = ph_q;
    stat_d = ST_MORE;
    ev_d   = EV_NONE;
    slot_d = '0;
    e_ph   = in_start_i ? PH_LINE : ph_q;
    if (accept) begin
      cmd_o.restart = in_start_i;
      ph_d          = e_ph;
      unique case (e_ph)
        PH_LINE, PH_HEAD: begin
          if (st_i.is_cr) begin
            stat_d = ST_MORE;
          end else if (st_i.is_lf) begin
            if (e_ph == PH_LINE) begin
              cmd_o.rl_end = 1'b1;
              if (st_i.rl_ok) begin
                ph_d = PH_HEAD;
                ev_d = EV_LINE;
              end else begin
                ph_d   = PH_ERR;
                stat_d = ST_ERR;
              end
            end else if (st_i.line_empty) begin
              ev_d = EV_END;
              if (st_i.body_go) begin
                ph_d = PH_BODY;
              end else begin
                cmd_o.body_clr = 1'b1;
                ph_d           = PH_DONE;
                stat_d         = ST_DONE;
              end
            end else begin
              cmd_o.hdr_end = 1'b1;
              unique case (st_i.hdr_res)
                HR_OK: begin
                  ev_d   = EV_HDR;
                  slot_d = st_i.slot;
                end
                HR_BIG: begin
                  ph_d   = PH_ERR;
                  stat_d = ST_BIG;
                end
                default: begin
                  ph_d   = PH_ERR;
                  stat_d = ST_ERR;
                end
              endcase
            end
          end else if (st_i.line_full) begin
            ph_d   = PH_ERR;
            stat_d = ST_ERR;
          end else begin
            cmd_o.push = 1'b1;
          end
        end
        PH_BODY: begin
          if (st_i.body_full) begin
            ph_d   = PH_ERR;
            stat_d = ST_BIG;
          end else begin
            cmd_o.body_push = 1'b1;
            ev_d            = EV_BODY;
            if (st_i.body_last) begin
              ph_d   = PH_DONE;
              stat_d = ST_DONE;
            end
          end
        end
        PH_DONE: stat_d = ST_DONE;
        default: stat_d = ST_ERR;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_LINE;
      ov_q     <= 1'b0;
      status_q <= '0;
      event_q  <= '0;
      slot_q   <= '0;
      res_q    <= '0;
    end else begin
      ph_q <= ph_d;
      if (in_ready_o) begin
        ov_q <= accept;
        if (accept) begin
          status_q <= stat_d;
          event_q  <= ev_d;
          slot_q   <= slot_d;
          res_q    <= res_i;
        end
      end
    end
  end

endmodule

@@ rtl/http_request_byte_parser.sv @@
// HTTP request byte parser.
// One request byte enters per beat on the slave stream: tdata carries the
// byte, tuser[0] is the start flag that clears all parser state before the
// byte is taken. Every accepted byte gives exactly one result beat on the
// master stream with status, event, method, declared content length, header
// slot and body byte count.
// Each result beat is registered in the cycle after its byte is accepted. One
// byte is taken every cycle unless the receiver stalls; the request-line tokens
// and header fields are checked as bytes go by; line ends add no stall.
// The result sits in an output register; a new byte is accepted whenever
// that register is empty or being drained in the same cycle, so a stalled
// receiver holds the result and back-pressures the input after one beat.
// Reset clears the parse phase, counters and output valid; the parser then
// expects the first byte of a request line.
module http_request_byte_parser #(
  parameter int LINE_MAX           = 128,
  parameter int BODY_MAX           = 1024,
  parameter int HEADER_STORE_BYTES = 512,
  parameter int HEADER_SLOTS       = 16,
  parameter int NAME_MAX           = 32,
  parameter int QUERY_MAX          = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] start_request
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [4:2] event_res, [7:5] method_code, [18:8] content_length,
  // [22:19] header_index, [33:23] body_count, [39:34] zero
  output logic [hrbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import hrbp_pkg::*;

  cmd_t       cmd;
  st_t        st;
  res_t       res_next, res_out;
  logic [1:0] status;
  logic [2:0] event_res;
  logic [3:0] slot;

  hrbp_datapath #(
    .LINE_MAX          (LINE_MAX),
    .BODY_MAX          (BODY_MAX),
    .HEADER_STORE_BYTES(HEADER_STORE_BYTES),
    .HEADER_SLOTS      (HEADER_SLOTS),
    .NAME_MAX          (NAME_MAX),
    .QUERY_MAX         (QUERY_MAX)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .byte_i(s_axis_tdata),
    .cmd_i (cmd),
    .st_o  (st),
    .res_o (res_next)
  );

  hrbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_start_i (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .st_i       (st),
    .res_i      (res_next),
    .status_o   (status),
    .event_o    (event_res),
    .slot_o     (slot),
    .res_o      (res_out)
  );

  assign m_axis_tdata = {6'b0, res_out.body_count, slot, res_out.content_length,
                         res_out.method, event_res, status};

endmodule

@@ rtl/hrbp_checker.sv @@
module hrbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import hrbp_pkg::*;

  // A held result beat keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Error results never carry an event.
  a_err_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == ST_ERR || m_axis_tdata[1:0] == ST_BIG)
    |-> m_axis_tdata[4:2] == EV_NONE)
    else $error("error result with an event");

  // The header slot is only reported with a stored header.
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4:2] != EV_HDR |-> m_axis_tdata[22:19] == 4'd0)
    else $error("header slot without header event");

  // A stored body byte always leaves a nonzero count.
  a_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4:2] == EV_BODY |-> m_axis_tdata[33:23] != 11'd0)
    else $error("body byte with zero count");

endmodule

bind http_request_byte_parser hrbp_checker u_hrbp_checker (.*);
